// ----- sv/dsmc_pkg.sv -----
package dsmc_pkg;

   localparam int SAMPLE_W       = 8;
   localparam int WINDOW_DEFAULT = 5;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [SAMPLE_W-1:0] MIN_RANGE_RESET  = 8'd25;
   localparam logic [SAMPLE_W-1:0] MAX_RANGE_RESET  = 8'd120;
   localparam logic [SAMPLE_W-1:0] CENTER_GAP_RESET = 8'd20;
   localparam logic [SAMPLE_W-1:0] FAR_RANGE        = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RANGE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_GAP = 2'd2;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } sample_pair_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

   typedef struct packed {
      sample_type min_range;
      sample_type max_range;
      sample_type center_gap;
   } range_cfg_type;

   typedef struct packed {
      sample_type left_median;
      sample_type right_median;
      sample_type center_range;
      logic       left_hit;
      logic       right_hit;
      logic       center_hit;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_SELECT,
      ST_EMIT
   } state_type;

endpackage

// ----- sv/dual_sonar_median_classifier.sv -----
// A request is taken only in idle, so a new one waits until the last result is emitted.
// The rank pass circulates each window once around the ring of cells, one hop a cycle;
//   the medians are then registered and the emit state loads the result register.
// Reset (synchronous, active high): both windows clear to zero, the range
//   registers return to 25/120/20 cm, and no result is pending.
module dual_sonar_median_classifier #(
   parameter int WINDOW = dsmc_pkg::WINDOW_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_write,
   input  logic [dsmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]      csr_wdata,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]      req_left_sample,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]      req_right_sample,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dsmc_pkg::SAMPLE_W-1:0]      rsp_left_median,
   output logic [dsmc_pkg::SAMPLE_W-1:0]      rsp_right_median,
   output logic [dsmc_pkg::SAMPLE_W-1:0]      rsp_center_range,
   output logic                               rsp_left_hit,
   output logic                               rsp_right_hit,
   output logic                               rsp_center_hit
);
   import dsmc_pkg::*;

   localparam int KW = $clog2(WINDOW);
   localparam logic [KW-1:0] LAST_STEP = KW'(WINDOW - 1);

   // Range and gap registers.
   range_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_RANGE:  cfg_in.min_range  = csr_wdata;
            CSR_MAX_RANGE:  cfg_in.max_range  = csr_wdata;
            CSR_CENTER_GAP: cfg_in.center_gap = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range  <= MIN_RANGE_RESET;
         cfg_ff.max_range  <= MAX_RANGE_RESET;
         cfg_ff.center_gap <= CENTER_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer: take a transaction, run the rank pass, pick the medians, emit.
   state_type     state_ff, state_in;
   logic [KW-1:0] step_ff, step_in;
   logic          req_take;
   logic          out_free;
   logic          emit;
   cell_ctrl_type ctrl;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_stall = 1'b1;
      emit      = 1'b0;
      ctrl.load = 1'b0;
      ctrl.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               step_in   = '0;
               state_in  = ST_RANK;
            end
         end
         ST_RANK: begin
            // Each hop compares every cell with one more member of its window.
            ctrl.step = 1'b1;
            step_in   = step_ff + KW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold until the result register is free or drains this cycle.
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Ring of cells: the window shifts through on load, and the circulating
   // copy advances one cell per rank step, wrapping from the last to the first.
   sample_pair_type        val_row  [WINDOW];
   sample_pair_type        circ_row [WINDOW];
   logic [WINDOW-1:0]      cand_left;
   logic [WINDOW-1:0]      cand_right;
   sample_pair_type        new_pair;

   assign new_pair.left  = req_left_sample;
   assign new_pair.right = req_right_sample;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      dsmc_cell #(
         .WINDOW(WINDOW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .shift_in  ((i == 0) ? new_pair : val_row[(i == 0) ? 0 : i - 1]),
         .circ_in   (circ_row[(i == 0) ? WINDOW - 1 : i - 1]),
         .val_out   (val_row[i]),
         .circ_out  (circ_row[i]),
         .cand_left (cand_left[i]),
         .cand_right(cand_right[i])
      );
   end

   // Every candidate cell holds the same value, so OR the flagged entries.
   sample_type left_pick, right_pick;

   always_comb begin
      left_pick  = '0;
      right_pick = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (cand_left[i]) begin
            left_pick = left_pick | val_row[i].left;
         end
         if (cand_right[i]) begin
            right_pick = right_pick | val_row[i].right;
         end
      end
   end

   sample_type left_med_ff, right_med_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SELECT) begin
         left_med_ff  <= left_pick;
         right_med_ff <= right_pick;
      end
   end

   result_type result;

   dsmc_classify u_classify (
      .left_median (left_med_ff),
      .right_median(right_med_ff),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // Result register: parts the sequencer from the downstream stall.
   result_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_median  = rsp_ff.left_median;
   assign rsp_right_median = rsp_ff.right_median;
   assign rsp_center_range = rsp_ff.center_range;
   assign rsp_left_hit     = rsp_ff.left_hit;
   assign rsp_right_hit    = rsp_ff.right_hit;
   assign rsp_center_hit   = rsp_ff.center_hit;

   a_rank_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RANK) && (step_ff == '0))
      else $error("rank pass did not start after a request transaction");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared without passing the emit state");

   a_center_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.center_hit) |-> (!rsp_ff.left_hit && !rsp_ff.right_hit))
      else $error("center hit reported together with a side hit");

   a_far_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.center_hit) |-> (rsp_ff.center_range == FAR_RANGE))
      else $error("center range not at far value without a center hit");

endmodule

// ----- sv/dsmc_cell.sv -----
module dsmc_cell #(
   parameter int WINDOW = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dsmc_pkg::cell_ctrl_type   ctrl,
   input  dsmc_pkg::sample_pair_type shift_in,
   input  dsmc_pkg::sample_pair_type circ_in,
   output dsmc_pkg::sample_pair_type val_out,
   output dsmc_pkg::sample_pair_type circ_out,
   output logic                      cand_left,
   output logic                      cand_right
);
   import dsmc_pkg::*;

   localparam int CW = $clog2(WINDOW + 1);
   localparam logic [CW-1:0] MID = CW'(WINDOW / 2);

   sample_pair_type val_ff, val_in;
   sample_pair_type circ_ff, circ_in_nx;
   logic [CW-1:0]   lt_left_ff, lt_left_in, le_left_ff, le_left_in;
   logic [CW-1:0]   lt_right_ff, lt_right_in, le_right_ff, le_right_in;

   // Load shifts the window by one cell; step compares against the passing value.
   always_comb begin
      val_in      = val_ff;
      circ_in_nx  = circ_ff;
      lt_left_in  = lt_left_ff;
      le_left_in  = le_left_ff;
      lt_right_in = lt_right_ff;
      le_right_in = le_right_ff;
      if (ctrl.load) begin
         val_in      = shift_in;
         circ_in_nx  = shift_in;
         lt_left_in  = '0;
         le_left_in  = '0;
         lt_right_in = '0;
         le_right_in = '0;
      end else if (ctrl.step) begin
         circ_in_nx  = circ_in;
         lt_left_in  = lt_left_ff  + CW'(circ_ff.left  <  val_ff.left);
         le_left_in  = le_left_ff  + CW'(circ_ff.left  <= val_ff.left);
         lt_right_in = lt_right_ff + CW'(circ_ff.right <  val_ff.right);
         le_right_in = le_right_ff + CW'(circ_ff.right <= val_ff.right);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      circ_ff     <= circ_in_nx;
      lt_left_ff  <= lt_left_in;
      le_left_ff  <= le_left_in;
      lt_right_ff <= lt_right_in;
      le_right_ff <= le_right_in;
   end

   assign val_out    = val_ff;
   assign circ_out   = circ_ff;
   assign cand_left  = (lt_left_ff <= MID) && (le_left_ff > MID);
   assign cand_right = (lt_right_ff <= MID) && (le_right_ff > MID);

endmodule

// ----- sv/dsmc_classify.sv -----
module dsmc_classify (
   input  dsmc_pkg::sample_type    left_median,
   input  dsmc_pkg::sample_type    right_median,
   input  dsmc_pkg::range_cfg_type cfg,
   output dsmc_pkg::result_type    result
);
   import dsmc_pkg::*;

   logic                left_ok, right_ok, center;
   sample_type          diff;
   logic [SAMPLE_W:0]   sum;

   always_comb begin
      left_ok  = (left_median > cfg.min_range) && (left_median <= cfg.max_range);
      right_ok = (right_median > cfg.min_range) && (right_median <= cfg.max_range);
      diff     = (left_median >= right_median) ? (left_median - right_median)
                                               : (right_median - left_median);
      center   = left_ok && right_ok && (diff < cfg.center_gap);
      sum      = {1'b0, left_median} + {1'b0, right_median};

      result.left_median  = left_median;
      result.right_median = right_median;
      result.center_range = center ? sum[SAMPLE_W:1] : FAR_RANGE;
      result.left_hit     = left_ok && !center;
      result.right_hit    = right_ok && !center;
      result.center_hit   = center;
   end

endmodule
